// ===== src/fca_pkg.sv =====
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants, codes and controller/datapath types for the FAT chain
// allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int TABLE_ENTRIES_DEF = 8192;
   localparam int DATA_BLOCKS_W     = 14;
   localparam logic [DATA_BLOCKS_W-1:0] DATA_BLOCKS_RST = 14'd8192;

   localparam logic [15:0] ENTRY_FREE = 16'h0000;
   localparam logic [15:0] ENTRY_END  = 16'hFFFF;

   localparam logic [2:0] FUNC_WRITE = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_ALLOC = 3'd2;
   localparam logic [2:0] FUNC_FREE  = 3'd3;
   localparam logic [2:0] FUNC_COUNT = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_OVERRUN = 2'd2;

   // result selection
   localparam logic [2:0] RES_ZERO_OK   = 3'd0;
   localparam logic [2:0] RES_RANGE0    = 3'd1;
   localparam logic [2:0] RES_RD        = 3'd2;
   localparam logic [2:0] RES_NONE      = 3'd3;
   localparam logic [2:0] RES_FOUND     = 3'd4;
   localparam logic [2:0] RES_CNT_OK    = 3'd5;
   localparam logic [2:0] RES_CNT_RANGE = 3'd6;
   localparam logic [2:0] RES_CNT_OVR   = 3'd7;

   typedef struct packed {
      logic       load;
      logic       rd_idx;
      logic       rd_cur;
      logic       scan;
      logic       wr_idx;
      logic       wr_walk;
      logic       wr_found;
      logic       wr_tail;
      logic       res_load;
      logic [2:0] res_sel;
   } fca_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       idx_ok;
      logic       link;
      logic       start_end;
      logic       cur_ok;
      logic       rd_free;
      logic       rd_end;
      logic       cnt_full;
      logic       scan_busy;
      logic       found_v;
      logic       tail_eq_found;
   } fca_stat_type;

endpackage

// ===== src/fca_req_if.sv =====
// ----------------------------------------------------------------------------
// fca_req_if
// Request channel: one command transaction per item.
// ----------------------------------------------------------------------------
interface fca_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [15:0] entry_index;
   logic [15:0] entry_value;
   logic        link_tail;

   modport source (output valid, func, entry_index, entry_value, link_tail, input ready);
   modport sink   (input valid, func, entry_index, entry_value, link_tail, output ready);
endinterface

// ===== src/fca_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fca_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface fca_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_value;
   logic [1:0]  status;

   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== src/fca_datapath.sv =====
// ----------------------------------------------------------------------------
// fca_datapath
// Table memory, request latch, walk pointer, scan counter and result register.
// ----------------------------------------------------------------------------
module fca_datapath #(
   parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fca_pkg::DATA_BLOCKS_W-1:0] csr_wr_data,
   input  logic [2:0]                       req_func,
   input  logic [15:0]                      req_entry_index,
   input  logic [15:0]                      req_entry_value,
   input  logic                             req_link_tail,
   input  fca_pkg::fca_cmd_type             cmd,
   output fca_pkg::fca_stat_type            stat,
   output logic [15:0]                      result_value,
   output logic [1:0]                       status
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int IW = $clog2(TABLE_ENTRIES + 1);

   logic [15:0] mem [TABLE_ENTRIES];

   logic [fca_pkg::DATA_BLOCKS_W-1:0] data_blocks_ff;
   logic [2:0]    func_ff;
   logic [15:0]   idx_ff;
   logic [15:0]   val_ff;
   logic          link_ff;
   logic [15:0]   cur_ff;
   logic [IW-1:0] cnt_ff;
   logic [IW-1:0] scan_ff;
   logic [IW-1:0] lim_ff;
   logic          pend_ff;
   logic [AW-1:0] pidx_ff;
   logic [AW-1:0] found_ff;
   logic          found_v_ff;
   logic [15:0]   rd_data_ff;
   logic [15:0]   res_val_ff;
   logic [1:0]    res_st_ff;

   logic [IW-1:0] lim_in;
   logic          scan_live;
   logic          hit;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [15:0]   res_val_in;
   logic [1:0]    res_st_in;

   always_comb begin
      if (32'(data_blocks_ff) < TABLE_ENTRIES) begin
         lim_in = IW'(data_blocks_ff);
      end else begin
         lim_in = IW'(TABLE_ENTRIES);
      end
   end

   assign scan_live = scan_ff < lim_ff;
   assign hit       = cmd.scan && pend_ff && !found_v_ff && (rd_data_ff == fca_pkg::ENTRY_FREE);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff[AW-1:0];
      if (cmd.rd_idx) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff[AW-1:0];
      end else if (cmd.rd_cur) begin
         rd_en   = 1'b1;
         rd_addr = cur_ff[AW-1:0];
      end else if (cmd.scan) begin
         rd_en   = scan_live;
      end
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff[AW-1:0];
      wr_data = val_ff;
      if (cmd.wr_walk) begin
         wr_addr = cur_ff[AW-1:0];
         wr_data = fca_pkg::ENTRY_FREE;
      end else if (cmd.wr_found) begin
         wr_addr = found_ff;
         wr_data = fca_pkg::ENTRY_END;
      end else if (cmd.wr_tail) begin
         wr_data = 16'(found_ff);
      end else if (!cmd.wr_idx) begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_blocks_ff <= fca_pkg::DATA_BLOCKS_RST;
         pend_ff        <= 1'b0;
         found_v_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            data_blocks_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            pend_ff    <= 1'b0;
            found_v_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= scan_live;
            if (hit && (func_ff == fca_pkg::FUNC_ALLOC)) begin
               found_v_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         idx_ff  <= req_entry_index;
         val_ff  <= req_entry_value;
         link_ff <= req_link_tail;
         cur_ff  <= req_entry_index;
         cnt_ff  <= '0;
         lim_ff  <= lim_in;
         scan_ff <= (req_func == fca_pkg::FUNC_ALLOC) ? IW'(1) : '0;
      end else begin
         if (cmd.scan) begin
            pidx_ff <= scan_ff[AW-1:0];
            if (scan_live) begin
               scan_ff <= scan_ff + IW'(1);
            end
            if (hit) begin
               if (func_ff == fca_pkg::FUNC_ALLOC) begin
                  found_ff <= pidx_ff;
               end else begin
                  cnt_ff <= cnt_ff + IW'(1);
               end
            end
         end
         if (cmd.wr_walk) begin
            cnt_ff <= cnt_ff + IW'(1);
            cur_ff <= rd_data_ff;
         end
      end
   end

   always_comb begin
      res_val_in = 16'h0000;
      res_st_in  = fca_pkg::ST_OK;
      case (cmd.res_sel)
         fca_pkg::RES_ZERO_OK: begin
            res_val_in = 16'h0000;
         end
         fca_pkg::RES_RANGE0: begin
            res_st_in = fca_pkg::ST_RANGE;
         end
         fca_pkg::RES_RD: begin
            res_val_in = rd_data_ff;
         end
         fca_pkg::RES_NONE: begin
            res_val_in = fca_pkg::ENTRY_END;
            res_st_in  = fca_pkg::ST_RANGE;
         end
         fca_pkg::RES_FOUND: begin
            res_val_in = 16'(found_ff);
         end
         fca_pkg::RES_CNT_OK: begin
            res_val_in = 16'(cnt_ff);
         end
         fca_pkg::RES_CNT_RANGE: begin
            res_val_in = 16'(cnt_ff);
            res_st_in  = fca_pkg::ST_RANGE;
         end
         fca_pkg::RES_CNT_OVR: begin
            res_val_in = 16'(cnt_ff);
            res_st_in  = fca_pkg::ST_OVERRUN;
         end
         default: begin
            res_st_in = fca_pkg::ST_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_val_ff <= res_val_in;
         res_st_ff  <= res_st_in;
      end
   end

   assign result_value = res_val_ff;
   assign status       = res_st_ff;

   assign stat.func          = func_ff;
   assign stat.idx_ok        = 32'(idx_ff) < TABLE_ENTRIES;
   assign stat.link          = link_ff;
   assign stat.start_end     = idx_ff == fca_pkg::ENTRY_END;
   assign stat.cur_ok        = 32'(cur_ff) < TABLE_ENTRIES;
   assign stat.rd_free       = rd_data_ff == fca_pkg::ENTRY_FREE;
   assign stat.rd_end        = rd_data_ff == fca_pkg::ENTRY_END;
   assign stat.cnt_full      = 32'(cnt_ff) >= TABLE_ENTRIES;
   assign stat.scan_busy     = scan_live || pend_ff;
   assign stat.found_v       = found_v_ff;
   assign stat.tail_eq_found = idx_ff == 16'(found_ff);

endmodule

// ===== src/fca_ctrl.sv =====
// ----------------------------------------------------------------------------
// fca_ctrl
// Command sequencer: decodes each request, steps the scan or the chain walk
// and hands the result to the response register.
// ----------------------------------------------------------------------------
module fca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fca_pkg::fca_stat_type stat,
   output fca_pkg::fca_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_WCHK  = 3'd2;
   localparam logic [2:0] S_WEVAL = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_AWR   = 3'd5;
   localparam logic [2:0] S_ALINK = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [2:0] sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.res_sel = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_FIN;
            case (stat.func)
               fca_pkg::FUNC_WRITE: begin
                  cmd.wr_idx = stat.idx_ok;
                  sel_in = stat.idx_ok ? fca_pkg::RES_ZERO_OK : fca_pkg::RES_RANGE0;
               end
               fca_pkg::FUNC_READ: begin
                  cmd.rd_idx = stat.idx_ok;
                  sel_in = stat.idx_ok ? fca_pkg::RES_RD : fca_pkg::RES_RANGE0;
               end
               fca_pkg::FUNC_ALLOC: begin
                  if (stat.link && !stat.idx_ok) begin
                     sel_in = fca_pkg::RES_NONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               fca_pkg::FUNC_FREE: begin
                  if (stat.start_end) begin
                     sel_in = fca_pkg::RES_ZERO_OK;
                  end else begin
                     state_in = S_WCHK;
                  end
               end
               fca_pkg::FUNC_COUNT: begin
                  state_in = S_SCAN;
               end
               default: begin
                  sel_in = fca_pkg::RES_RANGE0;
               end
            endcase
         end
         S_WCHK: begin
            if (!stat.cur_ok) begin
               sel_in   = fca_pkg::RES_CNT_RANGE;
               state_in = S_FIN;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = S_WEVAL;
            end
         end
         S_WEVAL: begin
            if (stat.rd_free) begin
               sel_in   = fca_pkg::RES_CNT_OK;
               state_in = S_FIN;
            end else if (stat.cnt_full) begin
               sel_in   = fca_pkg::RES_CNT_OVR;
               state_in = S_FIN;
            end else begin
               cmd.wr_walk = 1'b1;
               if (stat.rd_end) begin
                  sel_in   = fca_pkg::RES_CNT_OK;
                  state_in = S_FIN;
               end else begin
                  state_in = S_WCHK;
               end
            end
         end
         S_SCAN: begin
            if ((stat.func == fca_pkg::FUNC_ALLOC) && stat.found_v) begin
               state_in = S_AWR;
            end else if (!stat.scan_busy) begin
               sel_in = (stat.func == fca_pkg::FUNC_ALLOC) ? fca_pkg::RES_NONE
                                                           : fca_pkg::RES_CNT_OK;
               state_in = S_FIN;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_AWR: begin
            cmd.wr_found = 1'b1;
            sel_in       = fca_pkg::RES_FOUND;
            if (stat.link && !stat.tail_eq_found) begin
               state_in = S_ALINK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_ALINK: begin
            cmd.wr_tail = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= fca_pkg::RES_ZERO_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/fat_chain_allocator.sv =====
// ----------------------------------------------------------------------------
// fat_chain_allocator
// Write, read and unknown commands go from acceptance through LOAD to FIN.
// Allocate and count free scan one entry per cycle up to limit; free walks the
// chain link by link; limit = min(data_blocks, TABLE_ENTRIES).
// One transaction at a time; a pending response does not block acceptance.
// Reset: synchronous; control cleared, data_blocks set to 8192, table undefined.
// ----------------------------------------------------------------------------
module fat_chain_allocator #(
   parameter int TABLE_ENTRIES = fca_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [fca_pkg::DATA_BLOCKS_W-1:0] csr_wr_data,
   fca_req_if.sink                          req_chan,
   fca_rsp_if.source                        rsp_chan
);

   fca_pkg::fca_cmd_type  cmd;
   fca_pkg::fca_stat_type stat;

   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fca_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_func        (req_chan.func),
      .req_entry_index (req_chan.entry_index),
      .req_entry_value (req_chan.entry_value),
      .req_link_tail   (req_chan.link_tail),
      .cmd             (cmd),
      .stat            (stat),
      .result_value    (rsp_chan.result_value),
      .status          (rsp_chan.status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while a command is in progress");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.status != 2'd3)
      else $error("undefined status code");

   a_overrun_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == fca_pkg::ST_OVERRUN)
      |-> rsp_chan.result_value == 16'(TABLE_ENTRIES))
      else $error("overrun reported with wrong freed count");

endmodule
